/* rtl/assert_macros.svh */
// Assertion macros for RTL files that check themselves; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SOH_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked during reset too.
`define SOH_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/soh_pkg.sv */
// Types, constants and the arctangent table of the stick octant quantizer.
package soh_pkg;

    localparam int AXIS_BITS     = 16;
    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 24;
    localparam int STAGE_W       = $clog2(CORDIC_STAGES);
    localparam int FRAC_BITS     = 32;
    localparam int TURN_W        = 32;
    localparam int DATA_W        = AXIS_BITS + 2 + FRAC_BITS;
    localparam int SQ_W          = 2 * AXIS_BITS - 1;
    localparam int RADIUS_W      = 15;
    localparam int MARGIN_W      = 14;
    localparam int MAG_W         = (2 * AXIS_BITS > 2 * RADIUS_W) ? 2 * AXIS_BITS
                                                                  : 2 * RADIUS_W;
    localparam int HOLD_W        = ((ANGLE_BITS > MARGIN_W) ? ANGLE_BITS : MARGIN_W) + 2;
    localparam int OCT_W         = 4;
    localparam int OCT_IDX_W     = 3;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 15;

    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_RADIUS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HYST_MARGIN    = 1'd1;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd8192;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 14'd455;

    localparam logic [OCT_W-1:0] OCT_NEUTRAL = 4'd0;
    localparam logic [OCT_W-1:0] OCT_MAX     = 4'd8;

    typedef struct packed {
        logic [RADIUS_W-1:0] neutral_radius;
        logic [MARGIN_W-1:0] hysteresis_margin;
    } cfg_t;

    typedef struct packed {
        logic                neutral;
        logic [DATA_W-1:0]   x;
        logic [DATA_W-1:0]   y;
        logic [TURN_W-1:0]   acc;
    } cordic_t;

    // Arctangent of 2^-i in 2^-32 turn units.
    function automatic logic [TURN_W-1:0] atan_turn(input logic [STAGE_W-1:0] idx);
        logic [TURN_W-1:0] t;
        case (idx)
            STAGE_W'(0):  t = 32'h2000_0000;
            STAGE_W'(1):  t = 32'h12E4_051D;
            STAGE_W'(2):  t = 32'h09FB_385B;
            STAGE_W'(3):  t = 32'h0511_11D4;
            STAGE_W'(4):  t = 32'h028B_0D43;
            STAGE_W'(5):  t = 32'h0145_D7E1;
            STAGE_W'(6):  t = 32'h00A2_F61E;
            STAGE_W'(7):  t = 32'h0051_7C55;
            STAGE_W'(8):  t = 32'h0028_BE53;
            STAGE_W'(9):  t = 32'h0014_5F2E;
            STAGE_W'(10): t = 32'h000A_2F98;
            STAGE_W'(11): t = 32'h0005_17CC;
            STAGE_W'(12): t = 32'h0002_8BE6;
            STAGE_W'(13): t = 32'h0001_45F3;
            STAGE_W'(14): t = 32'h0000_A2F9;
            STAGE_W'(15): t = 32'h0000_517C;
            STAGE_W'(16): t = 32'h0000_28BE;
            STAGE_W'(17): t = 32'h0000_145F;
            STAGE_W'(18): t = 32'h0000_0A30;
            STAGE_W'(19): t = 32'h0000_0518;
            STAGE_W'(20): t = 32'h0000_028C;
            STAGE_W'(21): t = 32'h0000_0146;
            STAGE_W'(22): t = 32'h0000_00A3;
            STAGE_W'(23): t = 32'h0000_0051;
            default:      t = '0;
        endcase
        return t;
    endfunction

endpackage

/* rtl/soh_ifs.sv */
// Valid/ready stream interfaces for stick samples and octant results.
interface soh_sample_if import soh_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [AXIS_BITS-1:0] axis_x;
    logic signed [AXIS_BITS-1:0] axis_y;

    modport source (output valid, output axis_x, output axis_y, input ready);
    modport sink   (input valid, input axis_x, input axis_y, output ready);
endinterface

interface soh_result_if import soh_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OCT_W-1:0] octant;
    logic [OCT_W-1:0] candidate_octant;

    modport source (output valid, output octant, output candidate_octant, input ready);
    modport sink   (input valid, input octant, input candidate_octant, output ready);
endinterface

/* rtl/soh_prep.sv */
// Front stages: squared magnitude against the neutral radius, half-plane fold, scaling.
module soh_prep import soh_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        in_valid,
    input  logic signed [AXIS_BITS-1:0] axis_x,
    input  logic signed [AXIS_BITS-1:0] axis_y,
    input  cfg_t                        cfg,
    output logic                        out_valid,
    output cordic_t                     out_data
);

    logic                       a_valid_reg;
    logic [SQ_W-1:0]            a_sq_x_reg;
    logic [SQ_W-1:0]            a_sq_y_reg;
    logic [2*RADIUS_W-1:0]      a_r2_reg;
    logic signed [AXIS_BITS:0]  a_x_reg;
    logic signed [AXIS_BITS:0]  a_y_reg;
    logic                       a_neg_reg;

    logic                       b_valid_reg;
    cordic_t                    b_data_reg;

    logic signed [2*AXIS_BITS-1:0] prod_x;
    logic signed [2*AXIS_BITS-1:0] prod_y;
    logic [2*RADIUS_W-1:0]         prod_r;
    logic signed [AXIS_BITS:0]     ext_x;
    logic signed [AXIS_BITS:0]     ext_y;
    logic [MAG_W-1:0]              mag;
    cordic_t                       b_data_next;

    always_comb
    begin
        prod_x = axis_x * axis_x;
        prod_y = axis_y * axis_y;
        prod_r = {{RADIUS_W{1'b0}}, cfg.neutral_radius} *
                 {{RADIUS_W{1'b0}}, cfg.neutral_radius};
        ext_x  = {axis_x[AXIS_BITS-1], axis_x};
        ext_y  = {axis_y[AXIS_BITS-1], axis_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
        end
    end

    // Fold the left half-plane onto the right; a folded sample starts its turn at a half turn.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_sq_x_reg <= prod_x[SQ_W-1:0];
            a_sq_y_reg <= prod_y[SQ_W-1:0];
            a_r2_reg   <= prod_r;
            a_neg_reg  <= axis_x[AXIS_BITS-1];
            a_x_reg    <= axis_x[AXIS_BITS-1] ? -ext_x : ext_x;
            a_y_reg    <= axis_x[AXIS_BITS-1] ? -ext_y : ext_y;
        end
    end

    always_comb
    begin
        mag                 = MAG_W'(a_sq_x_reg) + MAG_W'(a_sq_y_reg);
        b_data_next.neutral = (mag <= MAG_W'(a_r2_reg));
        b_data_next.x       = {a_x_reg[AXIS_BITS], a_x_reg, {FRAC_BITS{1'b0}}};
        b_data_next.y       = {a_y_reg[AXIS_BITS], a_y_reg, {FRAC_BITS{1'b0}}};
        b_data_next.acc     = {a_neg_reg, {(TURN_W-1){1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

/* rtl/soh_cell.sv */
// One CORDIC vectoring cell: a single micro-rotation toward the x axis.
module soh_cell import soh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [STAGE_W-1:0] stage,
    input  logic               in_valid,
    input  cordic_t            in_data,
    output logic               out_valid,
    output cordic_t            out_data
);

    logic                     valid_reg;
    cordic_t                  data_reg;
    cordic_t                  data_next;
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;
    logic [TURN_W-1:0]        turn;

    always_comb
    begin
        dx   = $signed(in_data.y) >>> stage;
        dy   = $signed(in_data.x) >>> stage;
        turn = atan_turn(stage);
        data_next.neutral = in_data.neutral;
        // Rotate clockwise while y is non-negative, otherwise counter-clockwise.
        if (!in_data.y[DATA_W-1])
        begin
            data_next.x   = in_data.x + dx;
            data_next.y   = in_data.y - dy;
            data_next.acc = in_data.acc + turn;
        end
        else
        begin
            data_next.x   = in_data.x - dx;
            data_next.y   = in_data.y + dy;
            data_next.acc = in_data.acc - turn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/soh_decide.sv */
// Back stages: angle rounding, nearest octant, hysteresis against the held octant.
module soh_decide import soh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             in_valid,
    input  cordic_t          in_data,
    input  cfg_t             cfg,
    output logic             out_valid,
    output logic [OCT_W-1:0] octant,
    output logic [OCT_W-1:0] candidate_octant
);

    localparam logic [TURN_W-1:0]     ROUND_BIT = TURN_W'(1) << (TURN_W - 1 - ANGLE_BITS);
    localparam logic [ANGLE_BITS-1:0] HALF_OCT  = ANGLE_BITS'(1) << (ANGLE_BITS - 4);

    logic                    r1_valid_reg;
    logic                    r1_neutral_reg;
    logic [ANGLE_BITS-1:0]   r1_angle_reg;
    logic [OCT_IDX_W-1:0]    r1_cand_reg;

    logic                    out_valid_reg;
    logic [OCT_W-1:0]        octant_reg;
    logic [OCT_W-1:0]        cand_reg;
    logic [OCT_W-1:0]        last_octant_reg;
    logic [OCT_W-1:0]        last_octant_next;

    logic [TURN_W-1:0]       acc_round;
    logic [ANGLE_BITS-1:0]   angle;
    logic [ANGLE_BITS-1:0]   angle_shift;

    logic [OCT_W-1:0]        cand_oct;
    logic [OCT_W-1:0]        last_m1;
    logic [ANGLE_BITS-1:0]   centre;
    logic [ANGLE_BITS-1:0]   diff;
    logic [ANGLE_BITS:0]     other;
    logic [ANGLE_BITS:0]     wrap_dist;
    logic                    hold;
    logic [OCT_W-1:0]        result;

    always_comb
    begin
        acc_round   = in_data.acc + ROUND_BIT;
        angle       = acc_round[TURN_W-1 -: ANGLE_BITS];
        angle_shift = angle + HALF_OCT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            r1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            r1_neutral_reg <= in_data.neutral;
            r1_angle_reg   <= angle;
            r1_cand_reg    <= angle_shift[ANGLE_BITS-1 -: OCT_IDX_W];
        end
    end

    // Wrapped distance from the held octant's centre decides whether to keep it.
    always_comb
    begin
        cand_oct  = OCT_W'(r1_cand_reg) + OCT_W'(1);
        last_m1   = last_octant_reg - OCT_W'(1);
        centre    = {last_m1[OCT_IDX_W-1:0], {(ANGLE_BITS-OCT_IDX_W){1'b0}}};
        diff      = r1_angle_reg - centre;
        other     = (ANGLE_BITS+1)'(1) << ANGLE_BITS;
        other     = other - {1'b0, diff};
        wrap_dist = ({1'b0, diff} < other) ? {1'b0, diff} : other;
        hold      = (last_octant_reg != OCT_NEUTRAL) &&
                    (HOLD_W'(wrap_dist) <= HOLD_W'(HALF_OCT) + HOLD_W'(cfg.hysteresis_margin));
        if (r1_neutral_reg)
        begin
            result = OCT_NEUTRAL;
        end
        else if (hold)
        begin
            result = last_octant_reg;
        end
        else
        begin
            result = cand_oct;
        end
        last_octant_next = last_octant_reg;
        if (advance && r1_valid_reg)
        begin
            last_octant_next = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            last_octant_reg <= OCT_NEUTRAL;
        end
        else
        begin
            last_octant_reg <= last_octant_next;
            if (advance)
            begin
                out_valid_reg <= r1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            octant_reg <= result;
            cand_reg   <= r1_neutral_reg ? OCT_NEUTRAL : cand_oct;
        end
    end

    assign out_valid        = out_valid_reg;
    assign octant           = octant_reg;
    assign candidate_octant = cand_reg;

endmodule

/* rtl/stick_octant_hysteresis_top.sv */
// Stages from a sample transfer to its result: 2 front, 24 CORDIC cells, 2 back.
// Throughput: one sample per cycle while the result is taken; the 24-cell CORDIC row holds one sample in each cell.
// A stalled result freezes every stage, so nothing is dropped or overtaken.
// Reset: all stages empty, held octant neutral, neutral_radius 8192, hysteresis_margin 455.
// Configuration writes take effect at the next clock edge.
module stick_octant_hysteresis_top import soh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    soh_sample_if.sink            sample,
    soh_result_if.source          result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic    advance;
    cfg_t    cfg_reg;
    logic    chain_valid [0:CORDIC_STAGES];
    cordic_t chain_data  [0:CORDIC_STAGES];

    // Every stage moves together; hold all while the result is not taken.
    assign advance      = !result.valid || result.ready;
    assign sample.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.neutral_radius    <= RADIUS_RESET;
            cfg_reg.hysteresis_margin <= MARGIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_NEUTRAL_RADIUS: cfg_reg.neutral_radius    <= cfg_data[RADIUS_W-1:0];
                REG_HYST_MARGIN:    cfg_reg.hysteresis_margin <= cfg_data[MARGIN_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    soh_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (sample.valid),
        .axis_x    (sample.axis_x),
        .axis_y    (sample.axis_y),
        .cfg       (cfg_reg),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cell
        soh_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .stage     (STAGE_W'(g)),
            .in_valid  (chain_valid[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    soh_decide u_decide
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .in_valid         (chain_valid[CORDIC_STAGES]),
        .in_data          (chain_data[CORDIC_STAGES]),
        .cfg              (cfg_reg),
        .out_valid        (result.valid),
        .octant           (result.octant),
        .candidate_octant (result.candidate_octant)
    );

`include "assert_macros.svh"

    `SOH_ASSERT(a_neutral_pair, result.valid |-> ((result.octant == OCT_NEUTRAL) == (result.candidate_octant == OCT_NEUTRAL)), "octant and candidate disagree on neutral")
    `SOH_ASSERT(a_octant_range, result.valid |-> (result.octant <= OCT_MAX && result.candidate_octant <= OCT_MAX), "octant code out of range")
    `SOH_ASSERT(a_stall_blocks_input, (result.valid && !result.ready) |-> !sample.ready, "sample taken while result stalled")
    `SOH_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !result.valid, "result valid during reset")

endmodule

/* tb/octant_checker.sv */
// Checker for the stick octant quantizer: watches the channels, predicts each result and compares.
module octant_checker import soh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    soh_sample_if                 sample,
    soh_result_if                 result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    failures,
    output int                    backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_OCTANT = 1 << (ANGLE_BITS - 4);

    // Arctangent of 2^-i in 2^-32 turn units.
    localparam logic [TURN_W-1:0] ATAN_STEP [CORDIC_STAGES] = '{
        32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2E, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

    typedef struct packed {
        logic [OCT_W-1:0] octant;
        logic [OCT_W-1:0] candidate_octant;
    } octant_pair_t;

    octant_pair_t        octants_due[$];
    logic [RADIUS_W-1:0] radius;
    logic [MARGIN_W-1:0] margin;
    logic [OCT_W-1:0]    held_octant;

    always @(posedge clk or negedge rst_n)
    begin : watch
        longint                sx;
        longint                sy;
        longint                px;
        longint                py;
        longint                dx;
        longint                dy;
        longint                mag2;
        logic [TURN_W-1:0]     turn;
        logic [ANGLE_BITS-1:0] bearing;
        logic [ANGLE_BITS-1:0] shifted;
        logic [ANGLE_BITS-1:0] centre;
        logic [ANGLE_BITS-1:0] diff;
        int                    other;
        int                    wrap_dist;
        int                    stage;
        octant_pair_t          want;
        octant_pair_t          got;

        if (!rst_n)
        begin
            radius      = RADIUS_RESET;
            margin      = MARGIN_RESET;
            held_octant = OCT_NEUTRAL;
            octants_due.delete();
            backlog     = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_NEUTRAL_RADIUS: radius = cfg_data[RADIUS_W-1:0];
                    REG_HYST_MARGIN:    margin = cfg_data[MARGIN_W-1:0];
                    default:            ;
                endcase
            end

            if (sample.valid && sample.ready)
            begin
                sx   = longint'(sample.axis_x);
                sy   = longint'(sample.axis_y);
                mag2 = sx * sx + sy * sy;
                if (mag2 <= longint'(radius) * longint'(radius))
                begin
                    held_octant = OCT_NEUTRAL;
                    want.octant           = OCT_NEUTRAL;
                    want.candidate_octant = OCT_NEUTRAL;
                end
                else
                begin
                    // Fold the left half plane onto the right, then run the vectoring stages.
                    turn = '0;
                    if (sx < 0)
                    begin
                        sx   = -sx;
                        sy   = -sy;
                        turn = 32'h8000_0000;
                    end
                    px = sx * 64'sd4294967296;
                    py = sy * 64'sd4294967296;
                    for (stage = 0; stage < CORDIC_STAGES; stage++)
                    begin
                        dx = py >>> stage;
                        dy = px >>> stage;
                        if (py >= 0)
                        begin
                            px   = px + dx;
                            py   = py - dy;
                            turn = turn + ATAN_STEP[stage];
                        end
                        else
                        begin
                            px   = px - dx;
                            py   = py + dy;
                            turn = turn - ATAN_STEP[stage];
                        end
                    end
                    turn    = turn + (32'd1 << (TURN_W - 1 - ANGLE_BITS));
                    bearing = turn[TURN_W-1 -: ANGLE_BITS];

                    shifted = bearing + ANGLE_BITS'(HALF_OCTANT);
                    want.candidate_octant = OCT_W'(shifted[ANGLE_BITS-1 -: OCT_IDX_W]) + 1'b1;
                    want.octant           = want.candidate_octant;

                    // Hold the previous octant while inside its widened band.
                    if (held_octant >= 1 && held_octant <= OCT_MAX)
                    begin
                        centre    = ANGLE_BITS'(held_octant - 1) << (ANGLE_BITS - 3);
                        diff      = bearing - centre;
                        other     = (1 << ANGLE_BITS) - int'(diff);
                        wrap_dist = (int'(diff) < other) ? int'(diff) : other;
                        if (wrap_dist <= HALF_OCTANT + int'(margin))
                            want.octant = held_octant;
                    end
                    held_octant = want.octant;
                end
                octants_due.push_back(want);
            end

            if (result.valid && result.ready)
            begin
                got.octant           = result.octant;
                got.candidate_octant = result.candidate_octant;
                if (octants_due.size() == 0)
                begin
                    failures++;
                    $display("%0t: result transfer with nothing expected: octant %0d candidate %0d",
                             $time, got.octant, got.candidate_octant);
                end
                else
                begin
                    want = octants_due.pop_front();
                    if (got.octant !== want.octant)
                    begin
                        failures++;
                        $display("%0t: octant expected %0d, actual %0d",
                                 $time, want.octant, got.octant);
                    end
                    if (got.candidate_octant !== want.candidate_octant)
                    begin
                        failures++;
                        $display("%0t: candidate_octant expected %0d, actual %0d",
                                 $time, want.candidate_octant, got.candidate_octant);
                    end
                end
            end
            backlog = octants_due.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// Testbench top for the stick octant quantizer: clock, reset, stimulus, stalls and verdict.
module tb_top;
    import soh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  PIPE_LATENCY   = 28;
    localparam int  WATCHDOG_LIMIT = 1000;
    localparam real TWO_PI         = 6.283185307179586;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    failures;
    int                    backlog;

    bit                    no_idle;
    int                    samples_sent;
    logic [RADIUS_W-1:0]   cur_radius;
    logic [MARGIN_W-1:0]   cur_margin;

    soh_sample_if sample_ch ();
    soh_result_if result_ch ();

    stick_octant_hysteresis_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    octant_checker checker_i
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .backlog   (backlog)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic int to_axis(real v);
        if (v >= 32767.0)
            return 32767;
        if (v <= -32768.0)
            return -32768;
        return $rtoi(v < 0.0 ? v - 0.5 : v + 0.5);
    endfunction

    task automatic send_sample(input int ax, input int ay);
        int gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.axis_x <= AXIS_BITS'(ax);
        sample_ch.axis_y <= AXIS_BITS'(ay);
        sample_ch.valid  <= 1'b1;
        do @(posedge clk); while (!sample_ch.ready);
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic send_point(input real rad, input real ang);
        send_sample(to_axis(rad * $cos(ang)), to_axis(rad * $sin(ang)));
    endtask

    // Drop valid and hold off until every result is back.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (backlog != 0) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_NEUTRAL_RADIUS: cur_radius = value[RADIUS_W-1:0];
            REG_HYST_MARGIN:    cur_margin = value[MARGIN_W-1:0];
            default:            ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly smooth stick motion, plus neutral dips, band-edge probes and raw noise.
    task automatic drive_motion(input int goal);
        int  kind;
        int  len;
        int  k;
        int  half;
        int  target;
        real rad;
        real ang;
        real step;
        goal = samples_sent + goal;
        while (samples_sent < goal)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                len  = $urandom_range(6, 30);
                rad  = real'(cur_radius) + 1.0 + real'($urandom_range(0, 46341 - cur_radius));
                ang  = TWO_PI * real'($urandom_range(0, 65535)) / 65536.0;
                step = (real'($urandom_range(0, 2000)) - 1000.0) / 10000.0;
                for (k = 0; k < len; k++)
                begin
                    send_point(rad, ang);
                    ang = ang + step;
                    rad = rad + real'($urandom_range(0, 400)) - 200.0;
                end
            end
            else if (kind == 6)
            begin
                half = int'(cur_radius) * 7 / 10;
                len  = $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                    send_sample($urandom_range(0, 2 * half) - half,
                                $urandom_range(0, 2 * half) - half);
            end
            else if (kind == 7)
            begin
                // Settle on an octant centre, then sit near its hold edge or its rounding edge.
                target = $urandom_range(0, 7) * 8192;
                target = target + (($urandom_range(0, 1) == 1) ? 1 : -1) *
                         (4096 + (($urandom_range(0, 1) == 1) ? int'(cur_margin) : 0));
                rad = 20000.0 + real'($urandom_range(0, 12767));
                len = $urandom_range(2, 8);
                send_point(rad, TWO_PI * real'(target - (target % 8192)) / 65536.0);
                for (k = 1; k < len; k++)
                    send_point(rad, TWO_PI * real'(target + $urandom_range(0, 8) - 4) / 65536.0);
            end
            else
            begin
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++)
                    send_sample(int'($urandom), int'($urandom));
            end
        end
    endtask

    // Result side: draw a stall per result, then keep ready up until the transfer.
    initial
    begin
        int gap;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
            @(negedge clk);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL stick_octant_hysteresis_top");
        $finish;
    end

    initial
    begin
        int y;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = REG_NEUTRAL_RADIUS;
        cfg_data         = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.axis_x = '0;
        sample_ch.axis_y = '0;
        no_idle          = 1'b0;
        samples_sent     = 0;
        cur_radius       = RADIUS_RESET;
        cur_margin       = MARGIN_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Axis extremes, the neutral edge, and a sweep across the first octant boundary.
        send_sample(0, 0);
        send_sample(32767, 0);
        send_sample(-32768, 0);
        send_sample(0, 32767);
        send_sample(0, -32768);
        send_sample(32767, 32767);
        send_sample(-32768, -32768);
        send_sample(-32768, 32767);
        send_sample(32767, -32768);
        send_sample(8192, 0);
        send_sample(8193, 0);
        for (y = 12422; y <= 12430; y++)
            send_sample(30000, y);
        send_sample(30000, 0);
        send_sample(-32768, 0);
        send_sample(-32768, -1);
        settle();

        // Only the origin is neutral; the hold band is as wide as the register allows.
        write_reg(REG_NEUTRAL_RADIUS, '0);
        write_reg(REG_HYST_MARGIN, 15'h7FFF);
        send_sample(0, 0);
        send_sample(1, 0);
        send_sample(-1, -1);
        send_sample(30000, 0);
        send_sample(0, 30000);
        send_sample(-32768, 0);
        drive_motion(200);
        settle();

        write_reg(REG_NEUTRAL_RADIUS, CFG_DATA_W'(RADIUS_RESET));
        write_reg(REG_HYST_MARGIN, CFG_DATA_W'(MARGIN_RESET));
        no_idle = 1'b1;
        drive_motion(250);
        settle();
        no_idle = 1'b0;

        write_reg(REG_NEUTRAL_RADIUS, 15'd32767);
        write_reg(REG_HYST_MARGIN, 15'd8192);
        drive_motion(200);
        settle();

        write_reg(REG_NEUTRAL_RADIUS, CFG_DATA_W'($urandom_range(0, 20000)));
        write_reg(REG_HYST_MARGIN, '0);
        drive_motion(250);
        settle();

        write_reg(REG_NEUTRAL_RADIUS, CFG_DATA_W'($urandom));
        write_reg(REG_HYST_MARGIN, CFG_DATA_W'($urandom));
        drive_motion(200);
        settle();

        write_reg(REG_NEUTRAL_RADIUS, 15'd1);
        write_reg(REG_HYST_MARGIN, 15'd4096);
        drive_motion(250);

        sample_ch.valid <= 1'b0;
        while (backlog != 0) @(negedge clk);
        repeat (2 * PIPE_LATENCY) @(negedge clk);

        if (failures == 0 && backlog == 0)
            $display("PASS stick_octant_hysteresis_top");
        else
            $display("FAIL stick_octant_hysteresis_top");
        $finish;
    end

endmodule
